// ----- rtl/core/mvma_pkg.sv -----
// Shared types and codes of the matrix-vector multiply-add block.
package mvma_pkg;

    // Input kinds as they arrive in s_tuser.
    localparam logic [1:0] ACT_DATA = 2'd0;
    localparam logic [1:0] ACT_COEF = 2'd1;
    localparam logic [1:0] ACT_BIAS = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_COEF,
        OP_BIAS
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [3:0]         row;
        logic [4:0]         col;
        logic signed [31:0] first;
        logic signed [31:0] second;
    } op_t;

    // Head of the operation queue as seen by the back end.
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_EMIT_RD,
        BK_EMIT_LD
    } bk_state_t;

endpackage

// ----- rtl/core/matrix_vector_multiply_add.sv -----
// Top level of the fixed-point matrix-vector multiply-add block.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid/s_tready    tdata: elem_first, elem_second, row_select,
//                                             column_select; tuser: action
//   m_*       out        m_tvalid/m_tready    tdata: result_value, output_index;
//                                             tlast: last_of_sample; tuser: last_of_batch
//   cfg_*     in         cfg_valid/cfg_ready  batch_samples
//
// A coefficient or bias write is taken from the queue in BK_IDLE and written to its store.
// A data word runs through BK_MAC, one multiply-accumulate per row and lane through the
// single coefficient RAM read port, and then waits in BK_DRAIN until the pipeline is empty.
// After the last word of a sample, BK_EMIT_RD reads each row's bias and BK_EMIT_LD adds it.
// A four-word queue lets the input side run ahead while the back end is busy or
// the output stalls. After reset the accumulators and counters are zero and
// batch_samples is one; the coefficient and bias stores hold nothing until written.
module matrix_vector_multiply_add
    import mvma_pkg::*;
#(
    parameter int OUTPUTS       = 10,
    parameter int COMPONENTS    = 32,
    parameter int LANES         = 2,
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] elem_first, [63:32] elem_second, [67:64] row_select,
    // [72:68] column_select, rest zero
    input  logic [79:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] result_value, [35:32] output_index, rest zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // [0] last_of_batch
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    q_head_t     head;
    logic        pop;
    logic [15:0] batch_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= 16'd1;
        end
        else if (cfg_valid)
        begin
            batch_reg <= cfg_data;
        end
    end

    mvma_front #(
        .OUTPUTS       (OUTPUTS),
        .COMPONENTS    (COMPONENTS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    mvma_back #(
        .OUTPUTS    (OUTPUTS),
        .COMPONENTS (COMPONENTS),
        .LANES      (LANES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .batch_samples (batch_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

    // The back end never takes a word from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("queue popped while empty");

    // The batch flag only rides on the final row of a sample.
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("batch flag without sample end");

    // The sample end marks the row with the highest index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tdata[35:32] == 4'(OUTPUTS - 1))
        else $error("sample end on wrong row");

endmodule

// ----- rtl/core/mvma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mvma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/mvma_front.sv -----
// Front end: accepts input words, sorts out unusable ones and queues the rest.
module mvma_front
    import mvma_pkg::*;
#(
    parameter int OUTPUTS       = 10,
    parameter int COMPONENTS    = 32,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output q_head_t     head,
    input  logic        pop
);

    localparam int SH = 32 - ELEMENT_WIDTH;

    op_t                 q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    op_t                 op_in;
    logic                keep;
    logic                push;
    logic                row_ok;
    logic                col_ok;
    logic signed [31:0]  first_sh;
    logic signed [31:0]  second_sh;

    assign s_tready = count_reg != QCNT_W'(QDEPTH);
    assign row_ok   = 32'(s_tdata[67:64]) < OUTPUTS;
    assign col_ok   = 32'(s_tdata[72:68]) < COMPONENTS;

    // Elements and stored values count only in their low ELEMENT_WIDTH bits.
    always_comb
    begin
        first_sh     = s_tdata[31:0] << SH;
        second_sh    = s_tdata[63:32] << SH;
        op_in.first  = first_sh >>> SH;
        op_in.second = second_sh >>> SH;
        op_in.row    = s_tdata[67:64];
        op_in.col    = s_tdata[72:68];
        op_in.kind   = OP_DATA;
        keep         = 1'b0;
        unique case (s_tuser)
            ACT_DATA:
            begin
                keep = 1'b1;
            end
            ACT_COEF:
            begin
                op_in.kind = OP_COEF;
                keep       = row_ok && col_ok;
            end
            ACT_BIAS:
            begin
                op_in.kind = OP_BIAS;
                keep       = row_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

    assign head.valid = count_reg != '0;
    assign head.op    = q_mem[rd_ptr_reg];

endmodule

// ----- rtl/core/mvma_back.sv -----
// Back end: coefficient and bias stores, multiply-accumulate pipeline, result output.
module mvma_back
    import mvma_pkg::*;
#(
    parameter int OUTPUTS    = 10,
    parameter int COMPONENTS = 32,
    parameter int LANES      = 2,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  q_head_t     head,
    output logic        pop,
    input  logic [15:0] batch_samples,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic [0:0]  m_tuser
);

    localparam int WORDS  = (COMPONENTS + LANES - 1) / LANES;
    localparam int ROW_W  = OUTPUTS > 1 ? $clog2(OUTPUTS) : 1;
    localparam int WORD_W = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int CDEPTH = OUTPUTS * COMPONENTS;
    localparam int CA_W   = CDEPTH > 1 ? $clog2(CDEPTH) : 1;

    bk_state_t            state_reg, state_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 lane_reg, lane_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [15:0]          sample_reg, sample_next;
    logic                 batch_end_reg, batch_end_next;
    logic                 s1_valid_reg, s2_valid_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          acc_reg [OUTPUTS];

    logic signed [31:0]   x0_reg, x1_reg, s1_x_reg;
    logic [ROW_W-1:0]     s1_row_reg, s2_row_reg;
    logic signed [63:0]   prod_reg;
    logic [31:0]          out_value_reg;
    logic [3:0]           out_index_reg;
    logic                 out_last_reg;
    logic                 out_batch_reg;

    logic                 row_last, lane_last, word_last, col_ok;
    logic                 start, issue, coef_re, bias_re, out_load, pipe_empty;
    logic                 coef_we, bias_we;
    logic [CA_W-1:0]      coef_wr_addr, coef_rd_addr;
    logic [ROW_W-1:0]     bias_wr_addr;
    logic [31:0]          coef_rd, bias_rd;
    logic [ROW_W-1:0]     acc_addr;
    logic [31:0]          acc_rd;
    logic signed [63:0]   prod_sh;
    logic [16:0]          sample_inc;
    logic [15:0]          limit;
    logic                 batch_end;

    assign row_last   = row_reg == ROW_W'(OUTPUTS - 1);
    assign lane_last  = 32'(lane_reg) == LANES - 1;
    assign word_last  = word_reg == WORD_W'(WORDS - 1);
    assign col_ok     = 32'(word_reg) * LANES + 32'(lane_reg) < COMPONENTS;
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && head.op.kind == OP_DATA)
                begin
                    state_next = BK_MAC;
                end
            end
            BK_MAC:
            begin
                if (row_last && lane_last)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = word_last ? BK_EMIT_RD : BK_IDLE;
                end
            end
            BK_EMIT_RD:
            begin
                state_next = BK_EMIT_LD;
            end
            BK_EMIT_LD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = row_last ? BK_IDLE : BK_EMIT_RD;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop      = 1'b0;
        issue    = 1'b0;
        bias_re  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = head.valid;
            end
            BK_MAC:
            begin
                issue = 1'b1;
            end
            BK_EMIT_RD:
            begin
                bias_re = 1'b1;
            end
            BK_EMIT_LD:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign start   = pop && head.op.kind == OP_DATA;
    assign coef_we = pop && head.op.kind == OP_COEF;
    assign bias_we = pop && head.op.kind == OP_BIAS;
    assign coef_re = issue && col_ok;

    assign coef_wr_addr = CA_W'(32'(head.op.row) * COMPONENTS + 32'(head.op.col));
    assign coef_rd_addr = CA_W'(32'(row_reg) * COMPONENTS + 32'(word_reg) * LANES
                                + 32'(lane_reg));
    assign bias_wr_addr = ROW_W'(head.op.row);

    mvma_ram #(
        .WIDTH (32),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (coef_wr_addr),
        .wr_data (head.op.first),
        .rd_en   (coef_re),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd)
    );

    mvma_ram #(
        .WIDTH (32),
        .DEPTH (OUTPUTS)
    ) u_bias_ram (
        .clk     (clk),
        .wr_en   (bias_we),
        .wr_addr (bias_wr_addr),
        .wr_data (head.op.first),
        .rd_en   (bias_re),
        .rd_addr (row_reg),
        .rd_data (bias_rd)
    );

    // The accumulators have one read port, shared by the adder and the output.
    assign acc_addr = state_reg == BK_EMIT_LD ? row_reg : s2_row_reg;
    assign acc_rd   = acc_reg[acc_addr];
    assign prod_sh  = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        limit      = batch_samples == '0 ? 16'd1 : batch_samples;
        sample_inc = {1'b0, sample_reg} + 17'd1;
        batch_end  = sample_inc >= {1'b0, limit};
    end

    always_comb
    begin
        row_next       = row_reg;
        lane_next      = lane_reg;
        word_next      = word_reg;
        sample_next    = sample_reg;
        batch_end_next = batch_end_reg;
        m_tvalid_next  = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            row_next      = row_last ? '0 : row_reg + 1'b1;
        end
        if (start)
        begin
            row_next  = '0;
            lane_next = 1'b0;
        end
        if (issue)
        begin
            row_next = row_last ? '0 : row_reg + 1'b1;
            if (row_last && !lane_last)
            begin
                lane_next = 1'b1;
            end
        end
        if (state_reg == BK_DRAIN && pipe_empty)
        begin
            row_next = '0;
            if (word_last)
            begin
                word_next      = '0;
                batch_end_next = batch_end;
                sample_next    = batch_end ? 16'd0 : sample_inc[15:0];
            end
            else
            begin
                word_next = word_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            row_reg       <= '0;
            lane_reg      <= 1'b0;
            word_reg      <= '0;
            sample_reg    <= '0;
            batch_end_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < OUTPUTS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            lane_reg      <= lane_next;
            word_reg      <= word_next;
            sample_reg    <= sample_next;
            batch_end_reg <= batch_end_next;
            s1_valid_reg  <= coef_re;
            s2_valid_reg  <= s1_valid_reg;
            m_tvalid_reg  <= m_tvalid_next;
            if (s2_valid_reg)
            begin
                acc_reg[s2_row_reg] <= acc_rd + prod_sh[31:0];
            end
            else if (out_load)
            begin
                acc_reg[row_reg] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x0_reg <= head.op.first;
            x1_reg <= head.op.second;
        end
        s1_x_reg   <= lane_reg ? x1_reg : x0_reg;
        s1_row_reg <= row_reg;
        s2_row_reg <= s1_row_reg;
        prod_reg   <= s1_x_reg * $signed(coef_rd);
        if (out_load)
        begin
            out_value_reg <= acc_rd + bias_rd;
            out_index_reg <= 4'(row_reg);
            out_last_reg  <= row_last;
            out_batch_reg <= row_last && batch_end_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'b0, out_index_reg, out_value_reg};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_batch_reg;

endmodule
